// ----- rtl/core/nlp_pkg.sv -----
// Package for the numeric literal parser: character codes, widths and the
// classified-character record passed from the front end to the back end.
// No dependencies.
`default_nettype none

package nlp_pkg;

  // Fixed field widths of the channels.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;

  // Default accumulator width and queue depth.
  localparam int unsigned ACC_BITS_DEF = 64;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Character codes recognized by the classifier.
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LO_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UP_F  = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CHAR_UP_X  = 8'h58;

  // Radix limits for digit checks.
  localparam logic [3:0] DEC_LIMIT = 4'd10;
  localparam logic [3:0] OCT_LIMIT = 4'd8;

  // One character after classification.
  typedef struct packed {
    logic [3:0] digit;     // digit value when is_hex is set
    logic       is_hex;    // 0-9, a-f or A-F
    logic       is_zero;
    logic       is_blank;  // space or tab
    logic       is_plus;
    logic       is_minus;
    logic       is_x;      // x or X
    logic       eot;       // last character of the text
  } cls_t;

endpackage : nlp_pkg

`default_nettype wire

// ----- rtl/core/nlp_if.sv -----
// Valid/ready channel interfaces for the numeric literal parser.
// Depends on nlp_pkg for the field widths.
`default_nettype none

interface nlp_char_if;
  logic                       valid;
  logic                       ready;
  logic [nlp_pkg::CHAR_W-1:0] character;
  logic                       end_of_text;

  modport source (output valid, output character, output end_of_text, input ready);
  modport sink   (input valid, input character, input end_of_text, output ready);
endinterface : nlp_char_if

interface nlp_value_if;
  logic                               valid;
  logic                               ready;
  logic signed [nlp_pkg::VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface : nlp_value_if

`default_nettype wire

// ----- rtl/core/nlp_front.sv -----
// Front end: accepts character transactions and classifies each byte.
// Depends on nlp_pkg and nlp_char_if.
`default_nettype none

module nlp_front (
  nlp_char_if.sink       char_i,
  input  wire logic      q_ready_i,
  output nlp_pkg::cls_t  q_data_o,
  output logic           q_push_o
);
  import nlp_pkg::*;

  logic [CHAR_W-1:0] c;
  logic [CHAR_W-1:0] off;

  assign c = char_i.character;

  // Transactions flow straight into the queue when it has room.
  assign char_i.ready = q_ready_i;
  assign q_push_o     = char_i.valid && q_ready_i;

  // Classify the byte: digit value and character class flags.
  always_comb begin
    off              = '0;
    q_data_o         = '0;
    q_data_o.eot     = char_i.end_of_text;
    q_data_o.is_blank = (c == CHAR_SPACE) || (c == CHAR_TAB);
    q_data_o.is_plus  = (c == CHAR_PLUS);
    q_data_o.is_minus = (c == CHAR_MINUS);
    q_data_o.is_x     = (c == CHAR_LO_X) || (c == CHAR_UP_X);
    q_data_o.is_zero  = (c == CHAR_ZERO);
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      off             = c - CHAR_ZERO;
      q_data_o.is_hex = 1'b1;
    end else if (c inside {[CHAR_LO_A:CHAR_LO_F]}) begin
      off             = c - CHAR_LO_A + CHAR_W'(DEC_LIMIT);
      q_data_o.is_hex = 1'b1;
    end else if (c inside {[CHAR_UP_A:CHAR_UP_F]}) begin
      off             = c - CHAR_UP_A + CHAR_W'(DEC_LIMIT);
      q_data_o.is_hex = 1'b1;
    end
    q_data_o.digit = off[3:0];
  end

endmodule : nlp_front

`default_nettype wire

// ----- rtl/core/nlp_queue.sv -----
// Short FIFO of classified characters between the front and back ends.
// Depends on nlp_pkg.
`default_nettype none

module nlp_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire nlp_pkg::cls_t data_i,
  output logic               ready_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output nlp_pkg::cls_t      data_o
);
  import nlp_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cls_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule : nlp_queue

`default_nettype wire

// ----- rtl/core/nlp_back.sv -----
// Back end: parse state machine, signed accumulator and output register.
// Depends on nlp_pkg and nlp_value_if.
`default_nettype none

module nlp_back #(
  parameter int unsigned ACC_BITS = nlp_pkg::ACC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire nlp_pkg::cls_t data_i,
  output logic               pop_o,
  nlp_value_if.source        value_o
);
  import nlp_pkg::*;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_POSTSIGN,
    PH_ZERO,
    PH_DEC,
    PH_OCT,
    PH_HEX,
    PH_STOP
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [ACC_BITS-1:0]   acc_q, acc_d;
  logic                  neg_q, neg_d;
  logic                  out_valid_q, out_valid_d;
  logic [VALUE_W-1:0]    out_value_q;

  logic [ACC_BITS-1:0]   dterm;
  logic [ACC_BITS-1:0]   scaled;
  logic                  dec_ok, oct_ok;

  // The accumulator holds the value with its sign already applied, so the
  // digit is subtracted for a negative literal and no final negation is needed.
  assign dterm  = neg_q ? (ACC_BITS'(0) - ACC_BITS'(data_i.digit))
                        : ACC_BITS'(data_i.digit);
  assign dec_ok = data_i.is_hex && (data_i.digit < DEC_LIMIT);
  assign oct_ok = data_i.is_hex && (data_i.digit < OCT_LIMIT);

  // Scale by the radix of the current phase with shifts.
  always_comb begin
    case (phase_q)
      PH_DEC:  scaled = (acc_q << 3) + (acc_q << 1);
      PH_OCT:  scaled = acc_q << 3;
      PH_HEX:  scaled = acc_q << 4;
      default: scaled = acc_q << 3;  // zero phase: first octal digit
    endcase
  end

  // A text end waits only for room in the output register.
  assign pop_o = valid_i && (!data_i.eot || !out_valid_q || value_o.ready);

  // The output register fills on a text end and drains when the sink takes it.
  assign out_valid_d = (pop_o && data_i.eot) || (out_valid_q && !value_o.ready);

  // Next parse state for the character at the head of the queue.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    neg_d   = neg_q;
    case (phase_q)
      PH_LEAD, PH_POSTSIGN: begin
        if (data_i.is_blank) begin
          phase_d = phase_q;
        end else if ((phase_q == PH_LEAD) && (data_i.is_plus || data_i.is_minus)) begin
          neg_d   = data_i.is_minus;
          phase_d = PH_POSTSIGN;
        end else if (data_i.is_zero) begin
          phase_d = PH_ZERO;
        end else if (dec_ok) begin
          acc_d   = dterm;
          phase_d = PH_DEC;
        end else begin
          phase_d = PH_STOP;
        end
      end
      PH_ZERO: begin
        if (data_i.is_x) begin
          phase_d = PH_HEX;
        end else if (oct_ok) begin
          acc_d   = scaled + dterm;
          phase_d = PH_OCT;
        end else begin
          phase_d = PH_STOP;
        end
      end
      PH_DEC, PH_OCT, PH_HEX: begin
        if ((phase_q == PH_DEC && dec_ok) || (phase_q == PH_OCT && oct_ok) ||
            (phase_q == PH_HEX && data_i.is_hex)) begin
          acc_d = scaled + dterm;
        end else begin
          phase_d = PH_STOP;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // State and output valid; the last character restores the reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEAD;
      acc_q       <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        if (data_i.eot) begin
          phase_q <= PH_LEAD;
          acc_q   <= '0;
          neg_q   <= 1'b0;
        end else begin
          phase_q <= phase_d;
          acc_q   <= acc_d;
          neg_q   <= neg_d;
        end
      end
    end
  end

  // Result payload, sign-extended from the accumulator width.
  always_ff @(posedge clk_i) begin
    if (pop_o && data_i.eot) begin
      out_value_q <= VALUE_W'(signed'(acc_d));
    end
  end

  assign value_o.valid = out_valid_q;
  assign value_o.value = signed'(out_value_q);

endmodule : nlp_back

`default_nettype wire

// ----- rtl/core/numeric_literal_parser.sv -----
// Top level of the numeric literal parser: front end, queue and back end.
// Depends on nlp_pkg, nlp_if, nlp_front, nlp_queue and nlp_back.
//
//   Channel  Direction  Payload                      Transaction
//   char_i   in         character[7:0], end_of_text  one byte of the text
//   value_o  out        value[63:0] signed           one parsed literal per text
//
// The back end takes one byte per cycle unless a result is stalled; the
// sustained rate is set by the single accumulator update per cycle.
// A result is registered in the cycle after its last byte leaves the queue.
// Reset is asynchronous and active low and clears the queue and parse state.
// A stalled result holds the queue only once a last byte is at its head; until then bytes keep moving.
`default_nettype none

module numeric_literal_parser #(
  parameter int unsigned ACC_BITS = nlp_pkg::ACC_BITS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  nlp_char_if.sink    char_i,
  nlp_value_if.source value_o
);
  import nlp_pkg::*;

  cls_t front_data;
  logic front_push;
  logic q_ready;
  logic q_valid;
  cls_t q_data;
  logic q_pop;

  // Classify incoming bytes.
  nlp_front u_front (
    .char_i    (char_i),
    .q_ready_i (q_ready),
    .q_data_o  (front_data),
    .q_push_o  (front_push)
  );

  // Decouple classification from parsing.
  nlp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .data_i  (front_data),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_data)
  );

  // Parse and deliver results.
  nlp_back #(
    .ACC_BITS (ACC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .data_i  (q_data),
    .pop_o   (q_pop),
    .value_o (value_o)
  );

endmodule : numeric_literal_parser

`default_nettype wire
